/* sv/cds_pkg.sv */
// Shared types, constants and helper functions for the calendar date subtractor.
// Holds the microcode program, datapath opcodes and jump conditions.
// No dependencies; imported by every other file of the block.
`default_nettype none

package cds_pkg;

   localparam int AMOUNT_BITS     = 10;
   localparam int AMOUNT_W        = 10;
   localparam int CMD_W           = 2;
   localparam int DAY_W           = 5;
   localparam int MONTH_W         = 4;
   localparam int YEAR_W          = 14;
   localparam int STATUS_W        = 2;
   localparam int N_BITS          = ((AMOUNT_BITS > AMOUNT_W) ? AMOUNT_BITS : AMOUNT_W) + 3;
   localparam int YEAR_MAX        = 9999;
   localparam int MONTHS_PER_YEAR = 12;
   localparam int DAYS_PER_WEEK   = 7;
   localparam int DIV100_RECIP    = 5243;
   localparam int DIV100_SHIFT    = 19;
   localparam int PROD_W          = 27;
   localparam int QUOT_W          = 8;
   localparam int PC_W            = 4;

   localparam logic [N_BITS-1:0]  AMT_MASK = N_BITS'((64'd1 << AMOUNT_BITS) - 64'd1);
   localparam logic [MONTH_W-1:0] JANUARY  = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] FEBRUARY = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] DECEMBER = MONTH_W'(12);
   localparam logic [DAY_W-1:0]   LEAP_FEB_DAYS = DAY_W'(29);
   localparam logic [DAY_W-1:0]   FEB_DAYS      = DAY_W'(28);

   typedef enum logic [CMD_W-1:0] {
      CMD_DAYS   = 2'd0,
      CMD_WEEKS  = 2'd1,
      CMD_MONTHS = 2'd2,
      CMD_YEAR   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_INVALID   = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      OP_NOP        = 4'd0,
      OP_LOAD       = 4'd1,
      OP_CHECK      = 4'd2,
      OP_DAY_STEP   = 4'd3,
      OP_YEAR_BACK  = 4'd4,
      OP_MONTH_BACK = 4'd5,
      OP_YEAR_ONE   = 4'd6,
      OP_CLAMP      = 4'd7,
      OP_EMIT       = 4'd8
   } op_type;

   typedef enum logic [3:0] {
      C_NEVER     = 4'd0,
      C_ALWAYS    = 4'd1,
      C_NO_REQ    = 4'd2,
      C_INVALID   = 4'd3,
      C_CMD_DAYS  = 4'd4,
      C_CMD_YEAR  = 4'd5,
      C_N_NONZERO = 4'd6,
      C_N_GE12    = 4'd7,
      C_OUT_BUSY  = 4'd8
   } cond_type;

   typedef struct packed {
      logic            accept;
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ucode_word_type;

   typedef struct packed {
      logic invalid;
      logic cmd_days;
      logic cmd_year;
      logic n_nonzero;
      logic n_ge12;
      logic out_busy;
   } dp_flags_type;

   // program addresses; the last step wraps to the first
   localparam logic [PC_W-1:0] PC_IDLE      = 4'd0;
   localparam logic [PC_W-1:0] PC_CHECK     = 4'd1;
   localparam logic [PC_W-1:0] PC_DISP_DAYS = 4'd2;
   localparam logic [PC_W-1:0] PC_DISP_YEAR = 4'd3;
   localparam logic [PC_W-1:0] PC_MON_YEARS = 4'd4;
   localparam logic [PC_W-1:0] PC_MON_REST  = 4'd5;
   localparam logic [PC_W-1:0] PC_YEAR_ONE  = 4'd6;
   localparam logic [PC_W-1:0] PC_CLAMP     = 4'd7;
   localparam logic [PC_W-1:0] PC_DAY_LOOP  = 4'd14;
   localparam logic [PC_W-1:0] PC_EMIT      = 4'd15;

   function automatic ucode_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_word_type w;
      case (pc)
         PC_IDLE:      w = '{1'b1, OP_LOAD,       C_NO_REQ,    PC_IDLE};
         PC_CHECK:     w = '{1'b0, OP_CHECK,      C_INVALID,   PC_EMIT};
         PC_DISP_DAYS: w = '{1'b0, OP_NOP,        C_CMD_DAYS,  PC_DAY_LOOP};
         PC_DISP_YEAR: w = '{1'b0, OP_NOP,        C_CMD_YEAR,  PC_YEAR_ONE};
         PC_MON_YEARS: w = '{1'b0, OP_YEAR_BACK,  C_N_GE12,    PC_MON_YEARS};
         PC_MON_REST:  w = '{1'b0, OP_MONTH_BACK, C_ALWAYS,    PC_CLAMP};
         PC_YEAR_ONE:  w = '{1'b0, OP_YEAR_ONE,   C_NEVER,     PC_IDLE};
         PC_CLAMP:     w = '{1'b0, OP_CLAMP,      C_ALWAYS,    PC_EMIT};
         PC_DAY_LOOP:  w = '{1'b0, OP_DAY_STEP,   C_N_NONZERO, PC_DAY_LOOP};
         PC_EMIT:      w = '{1'b0, OP_EMIT,       C_OUT_BUSY,  PC_EMIT};
         default:      w = '{1'b0, OP_NOP,        C_ALWAYS,    PC_IDLE};
      endcase
      return w;
   endfunction

   // 4/100/400 rule; quotient by 100 through a reciprocal multiply
   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic [PROD_W-1:0] prod;
      logic [QUOT_W-1:0] q;
      logic [YEAR_W-1:0] r;
      prod = PROD_W'(y) * PROD_W'(DIV100_RECIP);
      q    = prod[DIV100_SHIFT +: QUOT_W];
      r    = y - ((YEAR_W'(q) << 6) + (YEAR_W'(q) << 5) + (YEAR_W'(q) << 2));
      return ((y[1:0] == 2'b00) && (r != '0)) || ((r == '0) && (q[1:0] == 2'b00));
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                  input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      case (m)
         4'd2:                    len = leap ? LEAP_FEB_DAYS : FEB_DAYS;
         4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
         4'd1, 4'd3, 4'd5, 4'd7,
         4'd8, 4'd10, 4'd12:      len = DAY_W'(31);
         default:                 len = '0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

/* sv/cds_req_if.sv */
// Request channel: starting date, command and count with valid/ready.
// Depends on cds_pkg for field widths.
`default_nettype none

interface cds_req_if import cds_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [AMOUNT_W-1:0] amount;
   logic [DAY_W-1:0]    day_in;
   logic [MONTH_W-1:0]  month_in;
   logic [YEAR_W-1:0]   year_in;

   modport source (output valid, command, amount, day_in, month_in, year_in, input ready);
   modport sink   (input valid, command, amount, day_in, month_in, year_in, output ready);
endinterface

`default_nettype wire

/* sv/cds_rsp_if.sv */
// Response channel: resulting date and status with valid/ready.
// Depends on cds_pkg for field widths.
`default_nettype none

interface cds_rsp_if import cds_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DAY_W-1:0]    day_out;
   logic [MONTH_W-1:0]  month_out;
   logic [YEAR_W-1:0]   year_out;
   logic [STATUS_W-1:0] status;

   modport source (output valid, day_out, month_out, year_out, status, input ready);
   modport sink   (input valid, day_out, month_out, year_out, status, output ready);
endinterface

`default_nettype wire

/* sv/cds_sequencer.sv */
// Microcode sequencer: step counter, program ROM lookup and conditional jump.
// Depends on cds_pkg for the program and the datapath flag struct.
`default_nettype none

module cds_sequencer import cds_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  dp_flags_type flags,
   output op_type       op,
   output logic         accept
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   ucode_word_type  word;
   logic            hit;

   assign word   = ucode_rom(pc_ff);
   assign op     = word.op;
   assign accept = word.accept;

   always_comb begin
      case (word.cond)
         C_NEVER:     hit = 1'b0;
         C_ALWAYS:    hit = 1'b1;
         C_NO_REQ:    hit = !req_valid;
         C_INVALID:   hit = flags.invalid;
         C_CMD_DAYS:  hit = flags.cmd_days;
         C_CMD_YEAR:  hit = flags.cmd_year;
         C_N_NONZERO: hit = flags.n_nonzero;
         C_N_GE12:    hit = flags.n_ge12;
         C_OUT_BUSY:  hit = flags.out_busy;
         default:     hit = 1'b1;
      endcase
      pc_in = hit ? word.target : pc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

/* sv/cds_datapath.sv */
// Date datapath: working date, remaining count, status and the response register.
// Executes one opcode per cycle from the sequencer; depends on cds_pkg.
`default_nettype none

module cds_datapath import cds_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  op_type              op,
   input  logic                req_valid,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [AMOUNT_W-1:0] req_amount,
   input  logic [DAY_W-1:0]    req_day,
   input  logic [MONTH_W-1:0]  req_month,
   input  logic [YEAR_W-1:0]   req_year,
   input  logic                rsp_ready,
   output dp_flags_type        flags,
   output logic                rsp_valid,
   output logic [DAY_W-1:0]    rsp_day,
   output logic [MONTH_W-1:0]  rsp_month,
   output logic [YEAR_W-1:0]   rsp_year,
   output logic [STATUS_W-1:0] rsp_status
);

   cmd_type             cmd_ff, cmd_in;
   logic [DAY_W-1:0]    d0_ff, d0_in, d_ff, d_in;
   logic [MONTH_W-1:0]  m0_ff, m0_in, m_ff, m_in;
   logic [YEAR_W-1:0]   y0_ff, y0_in, y_ff, y_in;
   logic [N_BITS-1:0]   n_ff, n_in;
   status_type          status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DAY_W-1:0]    out_day_ff, out_day_in;
   logic [MONTH_W-1:0]  out_month_ff, out_month_in;
   logic [YEAR_W-1:0]   out_year_ff, out_year_in;
   status_type          out_status_ff, out_status_in;

   logic                leap_q;
   logic [DAY_W-1:0]    cur_len;
   logic [DAY_W-1:0]    prev_len;
   logic [N_BITS-1:0]   amt_n;
   logic [N_BITS-1:0]   amt_weeks;
   logic [MONTH_W-1:0]  n_small;
   logic                invalid;
   logic                out_busy;
   logic                year_zero;

   assign leap_q    = is_leap(y_ff);
   assign cur_len   = month_len(leap_q, m_ff);
   assign prev_len  = month_len(leap_q, m_ff - 1'b1);
   assign amt_n     = N_BITS'(req_amount) & AMT_MASK;
   assign amt_weeks = N_BITS'(amt_n * N_BITS'(DAYS_PER_WEEK));
   assign n_small   = n_ff[MONTH_W-1:0];
   assign year_zero = (y_ff == '0);
   assign out_busy  = rsp_valid_ff && !rsp_ready;

   always_comb begin
      invalid = 1'b0;
      if (y_ff > YEAR_W'(YEAR_MAX)) invalid = 1'b1;
      if (!(m_ff inside {[JANUARY:DECEMBER]})) invalid = 1'b1;
      if (d_ff == '0 || d_ff > cur_len) invalid = 1'b1;
   end

   assign flags.invalid   = invalid;
   assign flags.cmd_days  = (cmd_ff == CMD_DAYS) || (cmd_ff == CMD_WEEKS);
   assign flags.cmd_year  = (cmd_ff == CMD_YEAR);
   assign flags.n_nonzero = (n_ff != '0);
   assign flags.n_ge12    = (n_ff >= N_BITS'(MONTHS_PER_YEAR));
   assign flags.out_busy  = out_busy;

   always_comb begin
      cmd_in    = cmd_ff;
      d0_in     = d0_ff;
      m0_in     = m0_ff;
      y0_in     = y0_ff;
      d_in      = d_ff;
      m_in      = m_ff;
      y_in      = y_ff;
      n_in      = n_ff;
      status_in = status_ff;
      case (op)
         OP_LOAD: begin
            if (req_valid) begin
               cmd_in    = cmd_type'(req_command);
               d0_in     = req_day;
               m0_in     = req_month;
               y0_in     = req_year;
               d_in      = req_day;
               m_in      = req_month;
               y_in      = req_year;
               n_in      = (cmd_type'(req_command) == CMD_WEEKS) ? amt_weeks : amt_n;
               status_in = ST_OK;
            end
         end
         OP_CHECK: begin
            status_in = invalid ? ST_INVALID : ST_OK;
         end
         OP_DAY_STEP: begin
            if (n_ff != '0) begin
               if (n_ff < N_BITS'(d_ff)) begin
                  d_in = d_ff - DAY_W'(n_ff);
                  n_in = '0;
               end else if (m_ff == JANUARY && year_zero) begin
                  status_in = ST_UNDERFLOW;
                  n_in      = '0;
               end else begin
                  n_in = n_ff - N_BITS'(d_ff);
                  if (m_ff == JANUARY) begin
                     m_in = DECEMBER;
                     y_in = y_ff - 1'b1;
                     d_in = month_len(1'b0, DECEMBER);
                  end else begin
                     m_in = m_ff - 1'b1;
                     d_in = prev_len;
                  end
               end
            end
         end
         OP_YEAR_BACK: begin
            if (n_ff >= N_BITS'(MONTHS_PER_YEAR)) begin
               if (year_zero) begin
                  status_in = ST_UNDERFLOW;
                  n_in      = '0;
               end else begin
                  n_in = n_ff - N_BITS'(MONTHS_PER_YEAR);
                  y_in = y_ff - 1'b1;
               end
            end
         end
         OP_MONTH_BACK: begin
            if (n_small < m_ff) begin
               m_in = m_ff - n_small;
            end else if (year_zero) begin
               status_in = ST_UNDERFLOW;
            end else begin
               m_in = MONTH_W'(5'(m_ff) + 5'(MONTHS_PER_YEAR) - 5'(n_small));
               y_in = y_ff - 1'b1;
            end
            n_in = '0;
         end
         OP_YEAR_ONE: begin
            if (year_zero) begin
               status_in = ST_UNDERFLOW;
            end else begin
               y_in = y_ff - 1'b1;
            end
         end
         OP_CLAMP: begin
            d_in = (d0_ff <= cur_len) ? d0_ff : cur_len;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = out_busy;
      out_day_in    = out_day_ff;
      out_month_in  = out_month_ff;
      out_year_in   = out_year_ff;
      out_status_in = out_status_ff;
      if (op == OP_EMIT && !out_busy) begin
         rsp_valid_in  = 1'b1;
         out_status_in = status_ff;
         if (status_ff != ST_OK) begin
            out_day_in   = d0_ff;
            out_month_in = m0_ff;
            out_year_in  = y0_ff;
         end else begin
            out_day_in   = d_ff;
            out_month_in = m_ff;
            out_year_in  = y_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      d0_ff         <= d0_in;
      m0_ff         <= m0_in;
      y0_ff         <= y0_in;
      d_ff          <= d_in;
      m_ff          <= m_in;
      y_ff          <= y_in;
      n_ff          <= n_in;
      status_ff     <= status_in;
      out_day_ff    <= out_day_in;
      out_month_ff  <= out_month_in;
      out_year_ff   <= out_year_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_day    = out_day_ff;
   assign rsp_month  = out_month_ff;
   assign rsp_year   = out_year_ff;
   assign rsp_status = out_status_ff;

endmodule

`default_nettype wire

/* sv/calendar_date_subtractor_core.sv */
// Flow, request beat to response beat: an invalid date goes from the check step to emit;
// a day or week count runs the day loop, one month crossed per step, then emits; the
// one-year command steps back one year, a month command takes whole years and then the
// remaining months, and both then clamp the day and emit.
// Throughput: one request at a time; the next beat is taken in the cycle after the response
// register loads, while that response may still wait for its sink.
// Reset: synchronous; sequencer returns to its idle step and the response register empties.
`default_nettype none

module calendar_date_subtractor_core import cds_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   cds_req_if.sink   req_bus,
   cds_rsp_if.source rsp_bus
);

   op_type       op;
   logic         accept;
   dp_flags_type flags;

   assign req_bus.ready = accept;

   cds_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .flags     (flags),
      .op        (op),
      .accept    (accept)
   );

   cds_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .req_valid   (req_bus.valid),
      .req_command (req_bus.command),
      .req_amount  (req_bus.amount),
      .req_day     (req_bus.day_in),
      .req_month   (req_bus.month_in),
      .req_year    (req_bus.year_in),
      .rsp_ready   (rsp_bus.ready),
      .flags       (flags),
      .rsp_valid   (rsp_bus.valid),
      .rsp_day     (rsp_bus.day_out),
      .rsp_month   (rsp_bus.month_out),
      .rsp_year    (rsp_bus.year_out),
      .rsp_status  (rsp_bus.status)
   );

`ifndef SYNTH
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("request taken while previous one still in work");

   a_ok_date_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status == ST_OK |->
         rsp_bus.day_out != '0 && rsp_bus.month_out >= JANUARY &&
         rsp_bus.month_out <= DECEMBER && rsp_bus.year_out <= YEAR_W'(YEAR_MAX))
      else $error("ok response carries an impossible date");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.status == ST_OK || rsp_bus.status == ST_INVALID ||
         rsp_bus.status == ST_UNDERFLOW)
      else $error("response status out of range");
`endif

endmodule

`default_nettype wire
